/* rtl/mono_framebuffer_draw_engine_core_defines.svh */
// ----------------------------------------------------------------------------
// Frame-store draw engine assertion macros
// Shared concurrent assertion forms used by the draw engine modules.
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_CORE_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MFB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define MFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mfb_pkg.sv */
// ----------------------------------------------------------------------------
// Frame-store draw engine package
// Command codes, controller states and controller/datapath command types.
// ----------------------------------------------------------------------------
package mfb_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_POINT  = 3'd1,
    CMD_LINE   = 3'd2,
    CMD_CIRCLE = 3'd3,
    CMD_FCIRC  = 3'd4,
    CMD_FRECT  = 3'd5,
    CMD_IRECT  = 3'd6,
    CMD_READ   = 3'd7
  } cmd_t;

  // Pixel write modes.
  typedef enum logic [1:0] {
    MODE_CLR = 2'd0,
    MODE_SET = 2'd1,
    MODE_INV = 2'd2
  } pmode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_LINE_SETUP,
    ST_LINE,
    ST_CIRC_PTS,
    ST_CIRC_INIT,
    ST_RECT,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  // Where the pixel sequencer returns after a read-modify-write.
  typedef enum logic [1:0] {
    RET_DONE = 2'd0,
    RET_LINE = 2'd1,
    RET_CIRC = 2'd2,
    RET_RECT = 2'd3
  } ret_t;

  typedef struct packed {
    logic load;       // capture the request fields
    logic clr_start;  // restart the clear sweep
    logic clr_step;   // write one zero byte and advance
    logic pix_rd;     // read the byte under the current pixel
    logic pix_wr;     // write the modified byte back
    logic pt_a;       // current pixel comes from x_a/y_a
    logic pt_circ;    // current pixel is the selected circle outline point
    logic line_setup; // derive deltas for a span or a line
    logic line_step;  // one Bresenham step
    logic circ_init;  // start the circle walk
    logic circ_pt;    // select the next of eight points or four spans
    logic circ_step;  // midpoint update
    logic rect_init;
    logic rect_step;
    logic rd_issue;   // read the requested page byte
    logic rd_capture;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic line_end;
    logic circ_sub_last; // last point or span of this octant step
    logic circ_done;     // x > y
    logic rect_empty;
    logic rect_last;
    logic filled;
  } sts_t;

endpackage

/* rtl/mfb_datapath.sv */
// ----------------------------------------------------------------------------
// Frame-store draw engine datapath
// Frame memory, coordinate registers, Bresenham and midpoint arithmetic.
// ----------------------------------------------------------------------------
`include "mono_framebuffer_draw_engine_core_defines.svh"
module mfb_datapath #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mfb_pkg::ctl_t ctl,
  output mfb_pkg::sts_t sts,
  input  logic [2:0]    command,
  input  logic [7:0]    x_a,
  input  logic [7:0]    y_a,
  input  logic [7:0]    x_b,
  input  logic [7:0]    y_b,
  input  logic [7:0]    radius,
  input  logic [7:0]    width,
  input  logic [7:0]    height,
  input  logic          color,
  output logic [7:0]    read_data
);
  import mfb_pkg::*;

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int ROWS  = PAGES * 8;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // Captured request.
  cmd_t       cmd_r;
  logic [7:0] xa_r, ya_r, xb_r, yb_r, rad_r, w_r, h_r;
  pmode_t     mode_r;

  // Current pixel.
  logic [7:0] px_r, py_r;
  logic [7:0] px, py;

  // Line state.
  logic [7:0]  lx_r, ly_r, lx1_r, ly1_r;
  logic [8:0]  dx_r, dy_r;
  logic signed [10:0] err_r;
  logic        sx_r, sy_r;

  // Circle state.
  logic [7:0]  cx_r, cy_r;
  logic signed [11:0] d_r;
  logic [2:0]  sub_r;
  logic        circ_done_r;

  // Rectangle state.
  logic [7:0]  ri_r, rj_r;

  logic [AW:0] clr_r;
  logic [7:0]  rd_r;

  // Address of the byte under (px, py) and its in-range flag.
  logic        pix_ok;
  logic [AW-1:0] pix_addr;
  logic [7:0]  bitmask;
  logic [15:0] prod;
  always_comb begin
    pix_ok   = ({1'b0, px} < 9'(COLUMNS)) && ({1'b0, py} < 9'(ROWS));
    prod     = 16'(px) * 16'(PAGES) + 16'(py[7:3]);
    pix_addr = prod[AW-1:0];
    bitmask  = 8'(1) << py[2:0];
  end

  logic [AW-1:0] rd_addr;
  logic [15:0]   rprod;
  logic          rd_ok;
  always_comb begin
    rprod   = 16'(xa_r) * 16'(PAGES) + 16'(ya_r);
    rd_addr = rprod[AW-1:0];
    rd_ok   = ({1'b0, xa_r} < 9'(COLUMNS)) && ({1'b0, ya_r} < 9'(PAGES));
  end

  logic [AW-1:0] addr_r;
  logic          ok_r;
  logic [7:0]    mask_r;
  logic [7:0]    wbyte;
  always_comb begin
    case (mode_r)
      MODE_INV: wbyte = rdata_r ^ mask_r;
      MODE_SET: wbyte = rdata_r | mask_r;
      default:  wbyte = rdata_r & ~mask_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_step) begin
      mem[clr_r[AW-1:0]] <= 8'h00;
    end else if (ctl.pix_wr && ok_r) begin
      mem[addr_r] <= wbyte;
    end
    if (ctl.pix_rd) begin
      rdata_r <= mem[pix_addr];
    end else if (ctl.rd_issue) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pix_rd) begin
      addr_r <= pix_addr;
      ok_r   <= pix_ok;
      mask_r <= bitmask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (ctl.clr_start) begin
      clr_r <= '0;
    end else if (ctl.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end
  assign sts.clr_last = (clr_r == (AW+1)'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= cmd_t'(command);
      xa_r  <= x_a;
      ya_r  <= y_a;
      xb_r  <= x_b;
      yb_r  <= y_b;
      rad_r <= radius;
      w_r   <= width;
      h_r   <= height;
      if (cmd_t'(command) == CMD_IRECT) begin
        mode_r <= MODE_INV;
      end else begin
        mode_r <= color ? MODE_SET : MODE_CLR;
      end
    end
  end
  assign sts.filled = (cmd_r == CMD_FCIRC);

  // Span or line endpoints for this setup: a plain line uses the request,
  // a filled circle uses one of its four spans.
  logic [7:0] cx_p, cx_m, cy_p, cy_m, cxy_p, cxy_m, cyx_p, cyx_m;
  logic [7:0] ox, oy;
  always_comb begin
    ox    = {5'd0, 3'd0} | 8'(0);
    oy    = 8'(0);
    cx_p  = xa_r + cx_r;
    cx_m  = xa_r - cx_r;
    cxy_p = xa_r + cy_r;
    cxy_m = xa_r - cy_r;
    cy_p  = ya_r + cy_r;
    cy_m  = ya_r - cy_r;
    cyx_p = ya_r + cx_r;
    cyx_m = ya_r - cx_r;
    case (sub_r)
      3'd0: begin ox = cx_p;  oy = cy_p;  end
      3'd1: begin ox = cx_m;  oy = cy_p;  end
      3'd2: begin ox = cx_p;  oy = cy_m;  end
      3'd3: begin ox = cx_m;  oy = cy_m;  end
      3'd4: begin ox = cxy_p; oy = cyx_p; end
      3'd5: begin ox = cxy_m; oy = cyx_p; end
      3'd6: begin ox = cxy_p; oy = cyx_m; end
      default: begin ox = cxy_m; oy = cyx_m; end
    endcase
  end

  always_comb begin
    px = ctl.pt_a ? xa_r : (ctl.pt_circ ? ox : px_r);
    py = ctl.pt_a ? ya_r : (ctl.pt_circ ? oy : py_r);
  end

  logic [7:0] s_x0, s_y0, s_x1, s_y1;
  always_comb begin
    if (cmd_r == CMD_FCIRC) begin
      s_y0 = 8'(0);
      case (sub_r[1:0])
        2'd0: begin s_x0 = cx_m;  s_x1 = cx_p;  s_y0 = cy_p;  end
        2'd1: begin s_x0 = cx_m;  s_x1 = cx_p;  s_y0 = cy_m;  end
        2'd2: begin s_x0 = cxy_m; s_x1 = cxy_p; s_y0 = cyx_p; end
        default: begin s_x0 = cxy_m; s_x1 = cxy_p; s_y0 = cyx_m; end
      endcase
      s_y1 = s_y0;
    end else begin
      s_x0 = xa_r;
      s_y0 = ya_r;
      s_x1 = xb_r;
      s_y1 = yb_r;
    end
  end

  logic signed [11:0] e2;
  logic               stx, sty;
  always_comb begin
    e2  = {err_r, 1'b0};
    stx = e2 > -$signed({3'b000, dy_r});
    sty = e2 < $signed({3'b000, dx_r});
  end
  assign sts.line_end = (lx_r == lx1_r) && (ly_r == ly1_r);

  always_ff @(posedge clk) begin
    if (ctl.line_setup) begin
      lx_r  <= s_x0;
      ly_r  <= s_y0;
      lx1_r <= s_x1;
      ly1_r <= s_y1;
      dx_r  <= (s_x1 > s_x0) ? 9'(s_x1 - s_x0) : 9'(s_x0 - s_x1);
      dy_r  <= (s_y1 > s_y0) ? 9'(s_y1 - s_y0) : 9'(s_y0 - s_y1);
      sx_r  <= s_x0 < s_x1;
      sy_r  <= s_y0 < s_y1;
      err_r <= 11'($signed({3'b000, (s_x1 > s_x0) ? (s_x1 - s_x0) : (s_x0 - s_x1)}))
             - 11'($signed({3'b000, (s_y1 > s_y0) ? (s_y1 - s_y0) : (s_y0 - s_y1)}));
    end else if (ctl.line_step) begin
      err_r <= err_r - (stx ? 11'(dy_r) : 11'd0) + (sty ? 11'(dx_r) : 11'd0);
      if (stx) lx_r <= sx_r ? lx_r + 8'd1 : lx_r - 8'd1;
      if (sty) ly_r <= sy_r ? ly_r + 8'd1 : ly_r - 8'd1;
    end
  end

  // The walk ends once x passes y; a zero radius ends after its first step
  // even though y would go below zero.
  always_ff @(posedge clk) begin
    if (ctl.circ_init) begin
      cx_r        <= 8'd0;
      cy_r        <= rad_r;
      d_r         <= 12'sd3 - $signed({3'b000, rad_r, 1'b0});
      sub_r       <= 3'd0;
      circ_done_r <= 1'b0;
    end else if (ctl.circ_pt) begin
      sub_r <= sub_r + 3'd1;
    end else if (ctl.circ_step) begin
      sub_r <= 3'd0;
      cx_r  <= cx_r + 8'd1;
      if (d_r[11]) begin
        d_r         <= d_r + $signed({2'b00, cx_r, 2'b00}) + 12'sd6;
        circ_done_r <= cx_r >= cy_r;
      end else begin
        d_r  <= d_r + ($signed({2'b00, cx_r, 2'b00}) - $signed({2'b00, cy_r, 2'b00}))
              + 12'sd10;
        cy_r <= cy_r - 8'd1;
        circ_done_r <= ({1'b0, cx_r} + 9'd1) >= {1'b0, cy_r};
      end
    end
  end
  assign sts.circ_sub_last = (cmd_r == CMD_FCIRC) ? (sub_r == 3'd3) : (sub_r == 3'd7);
  assign sts.circ_done     = circ_done_r;

  always_ff @(posedge clk) begin
    if (ctl.rect_init) begin
      ri_r <= 8'd0;
      rj_r <= 8'd0;
    end else if (ctl.rect_step) begin
      if (rj_r == h_r - 8'd1) begin
        rj_r <= 8'd0;
        ri_r <= ri_r + 8'd1;
      end else begin
        rj_r <= rj_r + 8'd1;
      end
    end
  end
  assign sts.rect_empty = (w_r == 8'd0) || (h_r == 8'd0);
  assign sts.rect_last  = (ri_r == w_r - 8'd1) && (rj_r == h_r - 8'd1);

  // Current pixel register follows the line and rectangle walkers.
  always_ff @(posedge clk) begin
    if (ctl.line_setup) begin
      px_r <= s_x0;
      py_r <= s_y0;
    end else if (ctl.line_step) begin
      px_r <= stx ? (sx_r ? lx_r + 8'd1 : lx_r - 8'd1) : lx_r;
      py_r <= sty ? (sy_r ? ly_r + 8'd1 : ly_r - 8'd1) : ly_r;
    end else if (ctl.rect_init) begin
      px_r <= xa_r;
      py_r <= ya_r;
    end else if (ctl.rect_step) begin
      if (rj_r == h_r - 8'd1) begin
        px_r <= xa_r + ri_r + 8'd1;
        py_r <= ya_r;
      end else begin
        py_r <= ya_r + rj_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 8'd0;
    end else if (ctl.load) begin
      rd_r <= 8'd0;
    end else if (ctl.rd_capture) begin
      rd_r <= rd_ok ? rdata_r : 8'd0;
    end
  end
  assign read_data = rd_r;

  `MFB_ASSERT_IMPL(a_wr_ok, clk, rst_n, ctl.clr_step, !ctl.pix_wr, "clear and pixel write overlap")
  `MFB_ASSERT_IMPL(a_one_rd, clk, rst_n, ctl.pix_rd, !ctl.rd_issue, "two reads in one cycle")
  `MFB_ASSERT_NEXT(a_cap, clk, rst_n, ctl.rd_capture && !rd_ok, read_data == 8'd0, "bad read data")

endmodule

/* rtl/mfb_ctrl.sv */
// ----------------------------------------------------------------------------
// Frame-store draw engine controller
// Sequences clear, pixel, line, circle, rectangle and read requests.
// ----------------------------------------------------------------------------
`include "mono_framebuffer_draw_engine_core_defines.svh"
module mfb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [2:0]    command,
  output logic          out_tvalid,
  input  logic          out_tready,
  output mfb_pkg::ctl_t ctl,
  input  mfb_pkg::sts_t sts
);
  import mfb_pkg::*;

  state_t state_r, state_nxt;
  ret_t   ret_r, ret_nxt;
  logic   busy_clr_r;
  logic   accept;

  // Reset runs the clear sweep before any request is taken.
  assign in_tready  = (state_r == ST_IDLE) && !busy_clr_r;
  assign out_tvalid = (state_r == ST_DONE);
  assign accept     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      ret_r      <= RET_DONE;
      busy_clr_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      if (state_r == ST_CLEAR && sts.clr_last) begin
        busy_clr_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(command))
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_POINT: begin state_nxt = ST_PIX_RD; ret_nxt = RET_DONE; end
            CMD_LINE: state_nxt = ST_LINE_SETUP;
            CMD_CIRCLE, CMD_FCIRC: state_nxt = ST_CIRC_INIT;
            CMD_FRECT, CMD_IRECT: state_nxt = ST_RECT;
            default: state_nxt = ST_READ;
          endcase
        end
      end
      // The sweep after reset has no request behind it and gives no result.
      ST_CLEAR: if (sts.clr_last) state_nxt = busy_clr_r ? ST_IDLE : ST_DONE;
      ST_PIX_RD: state_nxt = ST_PIX_WR;
      ST_PIX_WR: begin
        case (ret_r)
          RET_LINE: state_nxt = sts.line_end ? (sts.filled ? ST_CIRC_PTS : ST_DONE)
                                             : ST_LINE;
          RET_CIRC: state_nxt = ST_CIRC_PTS;
          RET_RECT: state_nxt = sts.rect_last ? ST_DONE : ST_RECT;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_LINE_SETUP: begin state_nxt = ST_PIX_RD; ret_nxt = RET_LINE; end
      ST_LINE:       state_nxt = ST_PIX_RD;
      ST_CIRC_PTS: begin
        if (sts.circ_done) begin
          state_nxt = ST_DONE;
        end else if (sts.filled) begin
          state_nxt = ST_LINE_SETUP;
        end else begin
          state_nxt = ST_PIX_RD;
          ret_nxt   = RET_CIRC;
        end
      end
      ST_CIRC_INIT: state_nxt = ST_CIRC_PTS;
      ST_RECT: begin
        if (sts.rect_empty) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PIX_RD;
          ret_nxt   = RET_RECT;
        end
      end
      ST_READ:      state_nxt = ST_READ_WAIT;
      ST_READ_WAIT: state_nxt = ST_DONE;
      ST_DONE:      if (out_tready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // The first visit to the rectangle state after a request starts the walk.
  logic first_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b0;
    end else if (accept) begin
      first_r <= 1'b1;
    end else if (state_r == ST_RECT) begin
      first_r <= 1'b0;
    end
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      ST_IDLE: begin
        ctl.load      = accept;
        ctl.clr_start = accept;
      end
      ST_CLEAR: ctl.clr_step = 1'b1;
      ST_PIX_RD: begin
        ctl.pix_rd  = 1'b1;
        ctl.pt_a    = (ret_r == RET_DONE);
        ctl.pt_circ = (ret_r == RET_CIRC);
      end
      ST_PIX_WR: begin
        ctl.pix_wr = 1'b1;
        if (ret_r == RET_LINE && !sts.line_end) ctl.line_step = 1'b1;
        if (ret_r == RET_RECT && !sts.rect_last) ctl.rect_step = 1'b1;
        if ((ret_r == RET_CIRC) || (ret_r == RET_LINE && sts.line_end && sts.filled)) begin
          if (sts.circ_sub_last) ctl.circ_step = 1'b1;
          else ctl.circ_pt = 1'b1;
        end
      end
      ST_LINE_SETUP: ctl.line_setup = 1'b1;
      ST_CIRC_INIT: ctl.circ_init = 1'b1;
      ST_RECT: if (first_r) ctl.rect_init = 1'b1;
      ST_READ: ctl.rd_issue = 1'b1;
      ST_READ_WAIT: ctl.rd_capture = 1'b1;
      default: ctl = '0;
    endcase
  end

  `MFB_ASSERT_IMPL(a_rdy, clk, rst_n, in_tready, !out_tvalid, "ready while result pending")
  `MFB_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `MFB_ASSERT_IMPL(a_ld, clk, rst_n, ctl.load, state_r == ST_IDLE, "load outside idle")

endmodule

/* rtl/mono_framebuffer_draw_engine_core.sv */
// ----------------------------------------------------------------------------
// Monochrome frame-store draw engine
// Rasterizes points, lines, circles and rectangles into a column-by-page store.
// ----------------------------------------------------------------------------
// Usage: one drawing request enters on the in_ stream, one result leaves on
// the out_ stream (read_data, zero for requests other than a page read).
// A request is taken only while no other is in flight, and the next one can be
// taken in the cycle after the result is delivered. Each pixel takes a
// sequencing step, then a read and a write on the single frame memory port.
// A clear writes one byte per cycle. After reset the block sweeps the whole
// store to zero without giving a result; in_tready stays low until the sweep
// ends. When the receiver stalls, the result holds in its register and no new
// request is taken until it is delivered.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine_core #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[2:0], x_a[10:3], y_a[18:11], x_b[26:19], y_b[34:27],
  // radius[42:35], width[50:43], height[58:51], color[59], zero fill
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0]
  output logic [7:0]  out_tdata
);
  import mfb_pkg::*;

  ctl_t ctl;
  sts_t sts;

  mfb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .command(in_tdata[2:0]), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .ctl(ctl), .sts(sts)
  );

  mfb_datapath #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .command(in_tdata[2:0]), .x_a(in_tdata[10:3]), .y_a(in_tdata[18:11]),
    .x_b(in_tdata[26:19]), .y_b(in_tdata[34:27]), .radius(in_tdata[42:35]),
    .width(in_tdata[50:43]), .height(in_tdata[58:51]), .color(in_tdata[59]),
    .read_data(out_tdata)
  );

endmodule
